// File: rtl/gci_pkg.sv
// Shared types and constants for the LED gradient color interpolator.
// No dependencies; imported by the interfaces, the divider stage and the top level.
package gci_pkg;

    localparam int IDX_W          = 10;
    localparam int LEN_W          = 11;
    localparam int LEN_MAX        = (1 << LEN_W) - 1;
    localparam int RGB_W          = 24;
    localparam int CH_W           = 8;
    localparam int NCH            = 3;
    localparam int Q_W            = 8;
    localparam int NUM_W          = LEN_W + Q_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = RGB_W;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = Q_W / DIV_STAGES;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_STOPS    = 3'd0,
        CFG_STRIP_LENGTH = 3'd1,
        CFG_COLOR_START  = 3'd2,
        CFG_COLOR_MIDDLE = 3'd3,
        CFG_COLOR_END    = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        STOPS_NONE  = 2'd0,
        STOPS_ONE   = 2'd1,
        STOPS_TWO   = 2'd2,
        STOPS_THREE = 2'd3
    } t_stops;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] ca;
        logic [RGB_W-1:0] cb;
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] d;
    } t_sel_item;

    typedef struct packed {
        logic [IDX_W-1:0]               idx;
        logic [NUM_W-1:0]               dsh;
        logic [NCH-1:0][NUM_W-1:0]      rem;
        logic [NCH-1:0][Q_W-1:0]        quo;
    } t_div_item;

endpackage

// File: rtl/gci_pix_if.sv
// Pixel index channel: valid/ready handshake carrying one pixel index per item.
// Depends on gci_pkg for the field width.
interface gci_pix_if;
    logic                       valid;
    logic                       ready;
    logic [gci_pkg::IDX_W-1:0]  pixel_index;

    modport source (output valid, output pixel_index, input ready);
    modport sink   (input valid, input pixel_index, output ready);
endinterface

// File: rtl/gci_rgb_if.sv
// Color result channel: valid/ready handshake carrying pixel echo and packed RGB.
// Depends on gci_pkg for the field widths.
interface gci_rgb_if;
    logic                       valid;
    logic                       ready;
    logic [gci_pkg::IDX_W-1:0]  pixel_out;
    logic [gci_pkg::RGB_W-1:0]  rgb_value;

    modport source (output valid, output pixel_out, output rgb_value, input ready);
    modport sink   (input valid, input pixel_out, input rgb_value, output ready);
endinterface

// File: rtl/gci_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on gci_pkg for the index and data widths.
interface gci_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gci_pkg::CFG_IDX_W-1:0]  index;
    logic [gci_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/gci_div_stage.sv
// One pipeline stage of the restoring divider: two quotient bits for all channels.
// Depends on gci_pkg for t_div_item and the step count.
module gci_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  gci_pkg::t_div_item i_item,
    output logic               o_valid,
    output gci_pkg::t_div_item o_item
);
    import gci_pkg::*;

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;

    always_comb begin
        n_item = i_item;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int c = 0; c < NCH; c++) begin
                if (n_item.rem[c] >= n_item.dsh) begin
                    n_item.rem[c] = n_item.rem[c] - n_item.dsh;
                    n_item.quo[c] = {n_item.quo[c][Q_W-2:0], 1'b1};
                end else begin
                    n_item.quo[c] = {n_item.quo[c][Q_W-2:0], 1'b0};
                end
            end
            n_item.dsh = n_item.dsh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/led_gradient_color_interpolator.sv
// Throughput: one item per cycle while the output is ready; stages stall independently, so bubbles are absorbed
// and a waiting result does not block new items while any stage is empty.
// Pipeline: stop select, blend products, then four divider stages of two quotient bits.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
// Depends on gci_pkg, gci_pix_if, gci_rgb_if, gci_cfg_if and gci_div_stage.
module led_gradient_color_interpolator #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gci_pix_if.sink    i_pix,
    gci_rgb_if.source  o_rgb,
    gci_cfg_if.sink    i_cfg
);
    import gci_pkg::*;

    localparam logic [LEN_W-1:0] LEN_LIM =
        LEN_W'((MAX_PIXELS > LEN_MAX) ? LEN_MAX : MAX_PIXELS);

    logic [1:0]       r_num_stops;
    logic [LEN_W-1:0] r_strip_length;
    logic [RGB_W-1:0] r_color_start;
    logic [RGB_W-1:0] r_color_middle;
    logic [RGB_W-1:0] r_color_end;

    logic      r_v1;
    t_sel_item r_s1;
    t_sel_item n_s1;
    logic      r_v2;
    t_div_item r_s2;
    t_div_item n_s2;

    t_div_item w_div [0:DIV_STAGES];
    logic      w_vd  [0:DIV_STAGES];
    logic      w_en  [0:DIV_STAGES-1];
    logic      w_en1;
    logic      w_en2;

    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_half;
    logic [LEN_W-1:0] w_idx;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_stops    <= STOPS_TWO;
            r_strip_length <= LEN_W'(60);
            r_color_start  <= '0;
            r_color_middle <= '0;
            r_color_end    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_NUM_STOPS:    r_num_stops    <= i_cfg.data[1:0];
                CFG_STRIP_LENGTH: r_strip_length <= i_cfg.data[LEN_W-1:0];
                CFG_COLOR_START:  r_color_start  <= i_cfg.data[RGB_W-1:0];
                CFG_COLOR_MIDDLE: r_color_middle <= i_cfg.data[RGB_W-1:0];
                CFG_COLOR_END:    r_color_end    <= i_cfg.data[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    // Stall chain: a stage advances when it is empty or the next one advances
    always_comb begin
        w_en[DIV_STAGES-1] = !w_vd[DIV_STAGES] || o_rgb.ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !w_vd[k+1] || w_en[k+1];
        end
        w_en2 = !r_v2 || w_en[0];
        w_en1 = !r_v1 || w_en2;
    end

    assign i_pix.ready = w_en1;

    // Stage 1: pick stops, numerator index and denominator
    assign w_len  = (r_strip_length > LEN_LIM) ? LEN_LIM : r_strip_length;
    assign w_half = w_len >> 1;
    assign w_idx  = LEN_W'(i_pix.pixel_index);

    always_comb begin
        n_s1     = '0;
        n_s1.idx = i_pix.pixel_index;
        if (w_idx < w_len) begin
            unique case (t_stops'(r_num_stops))
                STOPS_NONE: begin
                    n_s1.ca = '0;
                end
                STOPS_ONE: begin
                    n_s1.ca = r_color_start;
                end
                STOPS_TWO: begin
                    n_s1.ca = r_color_start;
                    n_s1.cb = r_color_middle;
                    n_s1.n  = w_idx;
                    n_s1.d  = w_len - LEN_W'(1);
                end
                STOPS_THREE: begin
                    if (w_idx < w_half) begin
                        n_s1.ca = r_color_start;
                        n_s1.cb = r_color_middle;
                        n_s1.n  = w_idx;
                        n_s1.d  = w_half - LEN_W'(1);
                    end else begin
                        n_s1.ca = r_color_middle;
                        n_s1.cb = r_color_end;
                        n_s1.n  = w_idx - w_half;
                        n_s1.d  = w_half;
                    end
                end
                default: n_s1.ca = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
    end

    // Stage 2: form a*(d-n) + b*n; a zero denominator passes the first color
    always_comb begin
        logic [CH_W-1:0]  a;
        logic [CH_W-1:0]  b;
        logic [LEN_W-1:0] dn;
        n_s2     = '0;
        n_s2.idx = r_s1.idx;
        dn       = r_s1.d - r_s1.n;
        if (r_s1.d == '0) begin
            n_s2.dsh = NUM_W'(1) << (Q_W - 1);
        end else begin
            n_s2.dsh = NUM_W'(r_s1.d) << (Q_W - 1);
        end
        for (int c = 0; c < NCH; c++) begin
            a = r_s1.ca[c*CH_W +: CH_W];
            b = r_s1.cb[c*CH_W +: CH_W];
            if (r_s1.d == '0) begin
                n_s2.rem[c] = NUM_W'(a);
            end else begin
                n_s2.rem[c] = NUM_W'(a) * NUM_W'(dn) + NUM_W'(b) * NUM_W'(r_s1.n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2 <= n_s2;
        end
    end

    assign w_div[0] = r_s2;
    assign w_vd[0]  = r_v2;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        gci_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[k]),
            .i_valid (w_vd[k]),
            .i_item  (w_div[k]),
            .o_valid (w_vd[k+1]),
            .o_item  (w_div[k+1])
        );
    end

    assign o_rgb.valid     = w_vd[DIV_STAGES];
    assign o_rgb.pixel_out = w_div[DIV_STAGES].idx;
    assign o_rgb.rgb_value = w_div[DIV_STAGES].quo;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2.dsh != '0))
        else $error("divisor entering divider is zero");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && w_vd[1] && w_vd[2] && w_vd[3] && w_vd[4] && !o_rgb.ready)
            |-> !i_pix.ready)
        else $error("input taken while every stage is full and stalled");

    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 || !r_v2) |-> i_pix.ready)
        else $error("input refused while front stages hold a bubble");

endmodule

// File: tb/tb_led_gradient_color_interpolator.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_gradient_color_interpolator: sends pixel indexes and register
// writes over valid/ready channels and checks every color against a local gradient predictor.
// Depends on gci_pkg and the gci_pix_if, gci_rgb_if and gci_cfg_if interfaces.
module tb_led_gradient_color_interpolator;
    import gci_pkg::*;

    localparam int MAX_PIX        = 1024;
    localparam int IDX_MAX        = (1 << IDX_W) - 1;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int CALM_OPS       = 150;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(CFG_COLOR_END + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;
    localparam logic [RGB_W-1:0]     BLACK         = '0;
    localparam logic [RGB_W-1:0]     WHITE         = '1;

    typedef struct {
        bit                    is_write;
        logic [IDX_W-1:0]      pixel;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] value;
    } t_strip_op;

    typedef struct {
        logic [IDX_W-1:0] pixel;
        logic [RGB_W-1:0] rgb;
    } t_pixel_color;

    logic i_clk;
    logic i_rst_n;

    gci_pix_if pix_if();
    gci_rgb_if rgb_if();
    gci_cfg_if cfg_if();

    led_gradient_color_interpolator #(.MAX_PIXELS(MAX_PIX)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_rgb   (rgb_if),
        .i_cfg   (cfg_if)
    );

    t_strip_op        strip_ops[$];
    t_pixel_color     color_fifo[$];
    t_pixel_color     due;
    t_stops           model_stops;
    logic [LEN_W-1:0] model_len;
    logic [RGB_W-1:0] model_start;
    logic [RGB_W-1:0] model_middle;
    logic [RGB_W-1:0] model_end;

    int colors_pending = 0;
    int quiet_cycles   = 0;
    int fail_cnt       = 0;
    int pixel_cnt      = 0;
    int color_cnt      = 0;
    int write_cnt      = 0;
    int mode_cnt[4]    = '{0, 0, 0, 0};
    bit calm           = 1'b0;
    bit pix_busy       = 1'b0;
    bit cfg_busy       = 1'b0;
    int send_gap       = 0;
    int recv_stall     = 0;
    bit take_pix;
    bit take_cfg;
    bit take_color;

    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a, b,
                                                    input int unsigned n, d);
        int unsigned frac_n;
        if (d == 0) return a;
        frac_n = (n > d) ? d : n;
        return CH_W'((32'(a) * (d - frac_n) + 32'(b) * frac_n) / d);
    endfunction

    function automatic logic [RGB_W-1:0] mix_colors(input logic [RGB_W-1:0] ca, cb,
                                                    input int unsigned n, d);
        logic [RGB_W-1:0] mixed;
        for (int ch = 0; ch < NCH; ch++) begin
            mixed[ch*CH_W +: CH_W] = mix_channel(ca[ch*CH_W +: CH_W],
                                                 cb[ch*CH_W +: CH_W], n, d);
        end
        return mixed;
    endfunction

    function automatic logic [RGB_W-1:0] color_at(input logic [IDX_W-1:0] pixel);
        int unsigned eff_len;
        int unsigned half;
        int unsigned pos;
        pos     = 32'(pixel);
        eff_len = (32'(model_len) > MAX_PIX) ? MAX_PIX : 32'(model_len);
        half    = eff_len / 2;
        if (pos >= eff_len) return BLACK;
        case (model_stops)
            STOPS_ONE: begin
                return model_start;
            end
            STOPS_TWO: begin
                return mix_colors(model_start, model_middle, pos, eff_len - 1);
            end
            STOPS_THREE: begin
                if (pos < half) return mix_colors(model_start, model_middle, pos, half - 1);
                return mix_colors(model_middle, model_end, pos - half, half);
            end
            default: begin
                return BLACK;
            end
        endcase
    endfunction

    task automatic queue_pixel(input logic [IDX_W-1:0] p);
        strip_ops.push_back('{is_write: 1'b0, pixel: p, reg_index: '0, value: '0});
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] v);
        strip_ops.push_back('{is_write: 1'b1, pixel: '0, reg_index: index, value: v});
    endtask

    task automatic queue_gradient(input logic [CFG_DATA_W-1:0] stops_word, len_word,
                                  input logic [RGB_W-1:0] c0, c1, c2);
        queue_write(CFG_NUM_STOPS, stops_word);
        queue_write(CFG_STRIP_LENGTH, len_word);
        queue_write(CFG_COLOR_START, c0);
        queue_write(CFG_COLOR_MIDDLE, c1);
        queue_write(CFG_COLOR_END, c2);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            cfg_if.valid <= 1'b0;
            pix_busy = 1'b0;
            cfg_busy = 1'b0;
            send_gap = 0;
            calm <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) pix_busy = 1'b0;
            if (cfg_if.valid && cfg_if.ready) cfg_busy = 1'b0;
            if (!pix_busy && !cfg_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (strip_ops.size() > 0) begin
                    if (strip_ops[0].is_write) begin
                        if (!pix_if.valid && colors_pending == 0) begin
                            cfg_if.index <= strip_ops[0].reg_index;
                            cfg_if.data  <= strip_ops[0].value;
                            cfg_busy = 1'b1;
                            void'(strip_ops.pop_front());
                        end
                    end else if (!calm && $urandom_range(0, 11) == 0) begin
                        send_gap = $urandom_range(1, 14) - 1;
                    end else begin
                        pix_if.pixel_index <= strip_ops[0].pixel;
                        pix_busy = 1'b1;
                        void'(strip_ops.pop_front());
                    end
                end
            end
            pix_if.valid <= pix_busy;
            cfg_if.valid <= cfg_busy;
            calm <= strip_ops.size() < CALM_OPS;
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgb_if.ready <= 1'b0;
            recv_stall = 0;
            colors_pending <= 0;
            quiet_cycles <= 0;
            model_stops  = STOPS_TWO;
            model_len    = LEN_W'(60);
            model_start  = BLACK;
            model_middle = BLACK;
            model_end    = BLACK;
        end else begin
            take_pix   = pix_if.valid && pix_if.ready;
            take_cfg   = cfg_if.valid && cfg_if.ready;
            take_color = rgb_if.valid && rgb_if.ready;
            if (take_cfg) begin
                write_cnt++;
                case (cfg_if.index)
                    CFG_NUM_STOPS:    model_stops  = t_stops'(cfg_if.data[1:0]);
                    CFG_STRIP_LENGTH: model_len    = cfg_if.data[LEN_W-1:0];
                    CFG_COLOR_START:  model_start  = cfg_if.data[RGB_W-1:0];
                    CFG_COLOR_MIDDLE: model_middle = cfg_if.data[RGB_W-1:0];
                    CFG_COLOR_END:    model_end    = cfg_if.data[RGB_W-1:0];
                    default: ;
                endcase
            end
            if (take_color) begin
                color_cnt++;
                if (color_fifo.size() == 0) begin
                    $error("color for pixel %0d arrived with none expected", rgb_if.pixel_out);
                    fail_cnt++;
                end else begin
                    due = color_fifo.pop_front();
                    if (rgb_if.pixel_out !== due.pixel) begin
                        $error("pixel_out: expected %0d, got %0d", due.pixel, rgb_if.pixel_out);
                        fail_cnt++;
                    end
                    if (rgb_if.rgb_value !== due.rgb) begin
                        $error("rgb_value: expected %06h, got %06h (pixel %0d)",
                               due.rgb, rgb_if.rgb_value, due.pixel);
                        fail_cnt++;
                    end
                end
            end
            if (take_pix) begin
                pixel_cnt++;
                mode_cnt[model_stops]++;
                color_fifo.push_back('{pixel: pix_if.pixel_index,
                                       rgb: color_at(pix_if.pixel_index)});
            end
            colors_pending <= color_fifo.size();
            quiet_cycles <= (take_pix || take_cfg || take_color) ? 0 : quiet_cycles + 1;
            if (recv_stall > 0) begin
                recv_stall--;
                rgb_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_stall = $urandom_range(1, 14) - 1;
                rgb_if.ready <= 1'b0;
            end else begin
                rgb_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int                    queued;
        int                    burst;
        int                    top;
        int                    start;
        int                    len;
        bit                    sweep;
        logic [CFG_DATA_W-1:0] stops_word;
        logic [CFG_DATA_W-1:0] len_word;
        logic [RGB_W-1:0]      stop_color[NCH];

        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_index = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        rgb_if.ready       = 1'b0;

        // reset defaults, then extremes and corner cases
        queue_pixel(IDX_W'(0));
        queue_pixel(IDX_W'(60));
        queue_gradient(CFG_DATA_W'(STOPS_TWO), CFG_DATA_W'(MAX_PIX), BLACK, WHITE, BLACK);
        queue_pixel(IDX_W'(0));
        queue_pixel(IDX_W'(512));
        queue_pixel(IDX_W'(IDX_MAX));
        queue_gradient(CFG_DATA_W'(STOPS_THREE), CFG_DATA_W'(MAX_PIX), WHITE, BLACK, WHITE);
        queue_pixel(IDX_W'(0));
        queue_pixel(IDX_W'(511));
        queue_pixel(IDX_W'(512));
        queue_pixel(IDX_W'(IDX_MAX));
        queue_gradient(CFG_DATA_W'(STOPS_THREE), CFG_DATA_W'(2),
                       24'h123456, 24'hA5C35A, 24'hFEDCBA);
        queue_pixel(IDX_W'(0));
        queue_pixel(IDX_W'(1));
        queue_pixel(IDX_W'(2));
        queue_gradient(CFG_DATA_W'(STOPS_TWO), CFG_DATA_W'(1), 24'h80FF01, WHITE, WHITE);
        queue_pixel(IDX_W'(0));
        queue_pixel(IDX_W'(1));
        queue_gradient(CFG_DATA_W'(STOPS_ONE), CFG_DATA_W'(7), 24'h5A3CC3, WHITE, BLACK);
        queue_pixel(IDX_W'(6));
        queue_pixel(IDX_W'(7));
        queue_gradient(CFG_DATA_W'(STOPS_NONE), CFG_DATA_W'(7), WHITE, WHITE, WHITE);
        queue_pixel(IDX_W'(3));
        queue_gradient(CFG_DATA_W'(STOPS_TWO), CFG_DATA_W'(0), WHITE, WHITE, WHITE);
        queue_pixel(IDX_W'(0));
        queue_gradient(CFG_DATA_W'(STOPS_TWO), CFG_DATA_W'(LEN_MAX),
                       24'h0F0F0F, 24'hF0F0F0, BLACK);
        queue_pixel(IDX_W'(IDX_MAX));
        queue_write(CFG_UNUSED_LO, WHITE);
        queue_write(CFG_UNUSED_HI, 24'h000001);
        queue_pixel(IDX_W'(10));

        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:          stops_word = CFG_DATA_W'(STOPS_NONE);
                1:          stops_word = CFG_DATA_W'(STOPS_ONE);
                2, 3, 4, 5: stops_word = CFG_DATA_W'(STOPS_TWO);
                default:    stops_word = CFG_DATA_W'(STOPS_THREE);
            endcase
            case ($urandom_range(0, 19))
                0:       len = 0;
                1:       len = 1;
                2:       len = 2;
                3:       len = MAX_PIX;
                4:       len = LEN_MAX;
                5:       len = $urandom_range(MAX_PIX + 1, LEN_MAX);
                6:       len = $urandom_range(3, MAX_PIX);
                default: len = $urandom_range(3, 64);
            endcase
            len_word = CFG_DATA_W'(len);
            if ($urandom_range(0, 3) == 0) begin
                stops_word = stops_word | (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(3));
                len_word   = len_word | (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(LEN_MAX));
            end
            for (int c = 0; c < NCH; c++) begin
                case ($urandom_range(0, 5))
                    0:       stop_color[c] = BLACK;
                    1:       stop_color[c] = WHITE;
                    default: stop_color[c] = RGB_W'($urandom);
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                queue_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                            CFG_DATA_W'($urandom));
            queue_gradient(stops_word, len_word, stop_color[0], stop_color[1], stop_color[2]);

            // half the bursts sweep in order along the strip, the rest are scattered; both reach past its end
            top   = (len + 1 > IDX_MAX) ? IDX_MAX : len + 1;
            burst = $urandom_range(8, 60);
            sweep = 1'($urandom_range(0, 1));
            start = $urandom_range(0, top);
            for (int k = 0; k < burst; k++) begin
                if (sweep) queue_pixel(IDX_W'((start + k) % (top + 1)));
                else if ($urandom_range(0, 7) == 0) queue_pixel(IDX_W'($urandom_range(0, IDX_MAX)));
                else queue_pixel(IDX_W'($urandom_range(0, top)));
            end
            queued += burst;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (strip_ops.size() != 0 || pix_if.valid || cfg_if.valid || color_fifo.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (color_fifo.size() != 0) begin
            $error("%0d colors never arrived", color_fifo.size());
            fail_cnt++;
        end
        $display("covered %0d pixel items and %0d colors over %0d register writes",
                 pixel_cnt, color_cnt, write_cnt);
        $display("items per stop count: none %0d, one %0d, two %0d, three %0d",
                 mode_cnt[STOPS_NONE], mode_cnt[STOPS_ONE], mode_cnt[STOPS_TWO],
                 mode_cnt[STOPS_THREE]);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: led_gradient_color_interpolator.f
rtl/gci_pkg.sv
rtl/gci_pix_if.sv
rtl/gci_rgb_if.sv
rtl/gci_cfg_if.sv
rtl/gci_div_stage.sv
rtl/led_gradient_color_interpolator.sv
tb/tb_led_gradient_color_interpolator.sv
